// ===== sv/rsm_pkg.sv =====
// ----------------------------------------------------------------------------
// rsm_pkg: shared types and constants of the regex stream matcher
// Pattern metacharacters, register map, element and link types.
// ----------------------------------------------------------------------------
package rsm_pkg;

  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 64;
  localparam int LEN_W     = 5;
  localparam int REG_SEL_W = 2;
  localparam int PAT_BYTES = 16;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ANY   = 8'h3F;
  localparam logic [7:0] CH_END   = 8'h24;
  localparam logic [7:0] CH_BEGIN = 8'h5E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [REG_SEL_W-1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [REG_SEL_W-1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [REG_SEL_W-1:0] REG_PAT_LEN  = 2'd2;

  typedef struct packed {
    logic [7:0] lit;
    logic       any;
    logic       star;
  } elem_t;

  typedef struct packed {
    logic cl;
    logic adv;
    logic nx;
  } link_t;

  typedef struct packed {
    logic busy;
    logic anchor_start;
    logic anchor_end;
  } prog_flags_t;

  typedef struct packed {
    logic match_found;
    logic verdict_final;
  } result_t;

  typedef enum logic [2:0] {
    CS_IDLE = 3'b001,
    CS_INIT = 3'b010,
    CS_SCAN = 3'b100
  } cfg_state_t;

endpackage

// ===== sv/rsm_stream_ifs.sv =====
// ----------------------------------------------------------------------------
// rsm_stream_ifs: request channels of the regex stream matcher
// Text channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface rsm_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_marker;

  modport source (output valid, text_byte, end_marker, input ready);
  modport sink (input valid, text_byte, end_marker, output ready);
endinterface

interface rsm_result_if;
  logic valid;
  logic ready;
  logic match_found;
  logic verdict_final;

  modport source (output valid, match_found, verdict_final, input ready);
  modport sink (input valid, match_found, verdict_final, output ready);
endinterface

// ===== sv/rsm_config.sv =====
// ----------------------------------------------------------------------------
// rsm_config: configuration registers and pattern compiler
// Holds the pattern registers and, after reset and after each write, scans the
// pattern to build the element table and the anchor flags.
// ----------------------------------------------------------------------------
module rsm_config #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rsm_pkg::ADDR_W-1:0]    paddr,
  input  logic [rsm_pkg::DATA_W-1:0]    pwdata,
  output logic [rsm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output rsm_pkg::elem_t                elems [MAX_PATTERN],
  output logic [$clog2(MAX_PATTERN+1)-1:0] count,
  output rsm_pkg::prog_flags_t          flags
);
  import rsm_pkg::*;

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int PW = $clog2(MAX_PATTERN + 2);
  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [DATA_W-1:0]        pat_low;
  logic [DATA_W-1:0]        pat_high;
  logic [LEN_W-1:0]         pat_len;
  logic [2*DATA_W-1:0]      pat_all;
  logic [7:0]               pat [MAX_PATTERN];
  logic [CW-1:0]            lenc;
  logic [REG_SEL_W-1:0]     reg_sel;
  logic                     wr;
  cfg_state_t               state;
  logic [PW-1:0]            p;
  logic [PW-1:0]            p1;
  logic [CW-1:0]            t;
  logic                     anchor_start;
  logic                     anchor_end;
  logic                     a0;
  logic                     cur_ok;
  logic                     nxt_ok;
  logic                     nxt_star;
  logic [7:0]               cur_b;
  logic                     elem_we;
  elem_t                    elem_new;

  assign pat_all = {pat_high, pat_low};
  assign reg_sel = paddr[ADDR_W-1:ADDR_W-REG_SEL_W];
  assign wr      = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pat[i] = pat_all[8*i +: 8];
    end
  end

  always_comb begin
    if (pat_len > LEN_W'(MAX_PATTERN)) begin
      lenc = CW'(MAX_PATTERN);
    end else begin
      lenc = pat_len[CW-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PAT_LOW:  prdata = pat_low;
      REG_PAT_HIGH: prdata = pat_high;
      REG_PAT_LEN:  prdata = DATA_W'(pat_len);
      default:      prdata = '0;
    endcase
  end

  assign a0       = (lenc != '0) && (pat[0] == CH_BEGIN);
  assign p1       = p + PW'(1);
  assign cur_b    = pat[p[IW-1:0]];
  assign cur_ok   = (p < PW'(lenc)) && (cur_b != CH_NUL);
  assign nxt_ok   = (p1 < PW'(lenc)) && (pat[p1[IW-1:0]] != CH_NUL);
  assign nxt_star = nxt_ok && (pat[p1[IW-1:0]] == CH_STAR);

  always_comb begin
    elem_new.lit  = cur_b;
    elem_new.any  = (cur_b == CH_ANY);
    elem_new.star = nxt_star;
    elem_we = (state == CS_SCAN) && !wr && cur_ok &&
              !(cur_b == CH_END && !nxt_ok && !nxt_star);
  end

  always_ff @(posedge clk) begin
    if (elem_we) begin
      elems[t[IW-1:0]] <= elem_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low      <= '0;
      pat_high     <= '0;
      pat_len      <= '0;
      state        <= CS_INIT;
      count        <= '0;
      anchor_start <= 1'b0;
      anchor_end   <= 1'b0;
      p            <= '0;
      t            <= '0;
    end else if (wr) begin
      unique case (reg_sel)
        REG_PAT_LOW:  pat_low  <= pwdata;
        REG_PAT_HIGH: pat_high <= pwdata;
        REG_PAT_LEN:  pat_len  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
      state <= CS_INIT;
    end else begin
      unique case (state)
        CS_IDLE: ;
        CS_INIT: begin
          anchor_start <= a0;
          anchor_end   <= 1'b0;
          p            <= a0 ? PW'(1) : '0;
          t            <= '0;
          state        <= CS_SCAN;
        end
        CS_SCAN: begin
          if (cur_ok) begin
            if (nxt_star) begin
              t <= t + CW'(1);
              p <= p + PW'(2);
            end else if (cur_b == CH_END && !nxt_ok) begin
              anchor_end <= 1'b1;
              p          <= p1;
            end else begin
              t <= t + CW'(1);
              p <= p1;
            end
          end else begin
            count <= t;
            state <= CS_IDLE;
          end
        end
        default: state <= CS_INIT;
      endcase
    end
  end

  assign flags.busy         = (state != CS_IDLE);
  assign flags.anchor_start = anchor_start;
  assign flags.anchor_end   = anchor_end;

endmodule

// ===== sv/rsm_cell.sv =====
// ----------------------------------------------------------------------------
// rsm_cell: one position of the bit-parallel NFA
// Holds one live-position bit, matches its element against the text byte and
// passes closure and advance terms to the next cell.
// ----------------------------------------------------------------------------
module rsm_cell #(
  parameter int IDX         = 0,
  parameter int MAX_PATTERN = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rsm_pkg::elem_t                   elem,
  input  logic [$clog2(MAX_PATTERN+1)-1:0] count,
  input  logic                             inject,
  input  logic [7:0]                       text_byte,
  input  logic                             step,
  input  logic                             clear,
  input  rsm_pkg::link_t                   lin,
  output rsm_pkg::link_t                   lout,
  output logic                             acc_cur,
  output logic                             acc_nxt
);
  import rsm_pkg::*;

  localparam int CW = $clog2(MAX_PATTERN + 1);

  logic act;
  logic used;
  logic is_last;
  logic in_range;
  logic cur;
  logic hit;
  logic adv;
  logic nx;

  assign used     = (CW'(IDX) < count);
  assign is_last  = (CW'(IDX) == count);
  assign in_range = (CW'(IDX) <= count);

  assign cur = (act & in_range) | inject | lin.cl;
  assign hit = cur & used & (elem.any | (elem.lit == text_byte));
  assign adv = (hit & elem.star) | lin.adv;
  assign nx  = adv | lin.nx;

  assign lout.cl  = cur & used & elem.star;
  assign lout.adv = hit & ~elem.star;
  assign lout.nx  = nx & used & elem.star;

  assign acc_cur = cur & is_last;
  assign acc_nxt = nx & is_last;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      act <= 1'b0;
    end else if (step) begin
      act <= nx;
    end
  end

endmodule

// ===== sv/regex_stream_matcher.sv =====
// ----------------------------------------------------------------------------
// regex_stream_matcher: streaming matcher for a small regex
// Text bytes run through a chain of NFA cells programmed from registers.
// ----------------------------------------------------------------------------
// The text channel carries one byte per request, or an end marker that closes
// the current text. Every request yields one result: the sticky found flag,
// and on the end marker the final verdict, after which the state is cleared.
// The pattern is written through the APB port at byte addresses 0, 8 and 16.
// A result is registered when its request is accepted, and one request is
// accepted per cycle while the skid register is empty and the compiler is
// idle; the whole NFA step is one pass along the cell chain. A result
// register and a skid register stand between the channels, so the block
// takes one more request while the receiver stalls and then holds ready low
// until the skid register drains. After reset and after every register write
// the pattern compiler scans the pattern; text ready stays low while it runs.
// Reset clears the live positions and the found flag and marks the start of
// a text.
// ----------------------------------------------------------------------------
module regex_stream_matcher #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  rsm_text_if.sink                   text,
  rsm_result_if.source               result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rsm_pkg::ADDR_W-1:0] paddr,
  input  logic [rsm_pkg::DATA_W-1:0] pwdata,
  output logic [rsm_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import rsm_pkg::*;

  localparam int CW = $clog2(MAX_PATTERN + 1);

  elem_t            elems [MAX_PATTERN];
  logic [CW-1:0]    count;
  prog_flags_t      flags;
  link_t            links [MAX_PATTERN+1];
  logic [MAX_PATTERN:0] acc_cur;
  logic [MAX_PATTERN:0] acc_nxt;

  logic    accept;
  logic    step;
  logic    clear;
  logic    inject;
  logic    found;
  logic    at_start;
  logic    found_run;
  result_t res;
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  rsm_config #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_config (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .elems  (elems),
    .count  (count),
    .flags  (flags)
  );

  assign links[0] = '0;
  assign inject   = ~flags.anchor_start | at_start;

  for (genvar k = 0; k <= MAX_PATTERN; k++) begin : g_cell
    if (k < MAX_PATTERN) begin : g_elem
      rsm_cell #(
        .IDX        (k),
        .MAX_PATTERN(MAX_PATTERN)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .elem     (elems[k]),
        .count    (count),
        .inject   ((k == 0) ? inject : 1'b0),
        .text_byte(text.text_byte),
        .step     (step),
        .clear    (clear),
        .lin      (links[k]),
        .lout     (links[k+1]),
        .acc_cur  (acc_cur[k]),
        .acc_nxt  (acc_nxt[k])
      );
    end else begin : g_tail
      rsm_cell #(
        .IDX        (k),
        .MAX_PATTERN(MAX_PATTERN)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .elem     ('0),
        .count    (count),
        .inject   ((k == 0) ? inject : 1'b0),
        .text_byte(text.text_byte),
        .step     (step),
        .clear    (clear),
        .lin      (links[k]),
        .lout     (),
        .acc_cur  (acc_cur[k]),
        .acc_nxt  (acc_nxt[k])
      );
    end
  end

  assign text.ready = ~skid_valid & ~flags.busy;
  assign accept     = text.valid & text.ready;
  assign step       = accept & ~text.end_marker;
  assign clear      = accept & text.end_marker;
  assign found_run  = found | (~flags.anchor_end & ((|acc_cur) | (|acc_nxt)));

  always_comb begin
    res.verdict_final = text.end_marker;
    if (text.end_marker) begin
      res.match_found = found | (|acc_cur);
    end else begin
      res.match_found = found_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found    <= 1'b0;
      at_start <= 1'b1;
    end else if (step) begin
      found    <= found_run;
      at_start <= 1'b0;
    end
  end

  assign pop = out_valid & result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else begin
        skid_valid <= 1'b1;
        skid_data  <= res;
      end
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.match_found   = out_data.match_found;
  assign result.verdict_final = out_data.verdict_final;

endmodule

// ===== sv/rsm_chk.sv =====
// ----------------------------------------------------------------------------
// rsm_chk: port-level checks of the regex stream matcher
// Watches the channels and the APB port and is bound to the top level.
// ----------------------------------------------------------------------------
module rsm_chk (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_found,
  input logic out_final,
  input logic psel,
  input logic penable,
  input logic pwrite,
  input logic pready
);

  a_reset_empty : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid right after reset.");

  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_found) && $stable(out_final)))
    else $error("Stalled result changed or dropped.");

  a_cfg_recompile : assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready) |=> !in_ready)
    else $error("Text accepted while the pattern is being compiled.");

  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !out_valid) |=> out_valid)
    else $error("Accepted request produced no result.");

endmodule

bind regex_stream_matcher rsm_chk u_rsm_chk (
  .clk      (clk),
  .rst      (rst),
  .in_valid (text.valid),
  .in_ready (text.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .out_found(result.match_found),
  .out_final(result.verdict_final),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .pready   (pready)
);

// ===== verif/regex_stream_matcher_tb.sv =====
// ----------------------------------------------------------------------------
// regex_stream_matcher_tb: self-checking bench for the regex stream matcher
// Programs patterns over APB, streams texts with random gaps and stalls on both
// channels, and compares every result with a bit-parallel NFA predictor.
// ----------------------------------------------------------------------------
module regex_stream_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsm_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam logic [7:0] CH_A = 8'h61;

  class match_tracker;
    logic [63:0] pat_low;
    logic [63:0] pat_high;
    logic [4:0]  pat_len;
    logic [7:0]  elem_lit [PAT_BYTES];
    bit          elem_any [PAT_BYTES];
    bit          elem_star [PAT_BYTES];
    int          elem_count;
    bit          anchored_start;
    bit          anchored_end;
    logic [16:0] live_pos;
    bit          found;
    bit          text_start;
    result_t     flags_due[$];
    int          errors;
    int          requests;
    int          texts_closed;
    int          texts_matched;

    function new();
      pat_low = '0;
      pat_high = '0;
      pat_len = '0;
      live_pos = '0;
      found = 1'b0;
      text_start = 1'b1;
      errors = 0;
      requests = 0;
      texts_closed = 0;
      texts_matched = 0;
      compile_program();
    endfunction

    function void compile_program();
      logic [7:0] pb [PAT_BYTES];
      int n;
      int p;
      n = (pat_len > PAT_BYTES) ? PAT_BYTES : int'(pat_len);
      for (int i = 0; i < n; i++) begin
        pb[i] = (i < 8) ? pat_low[8*i +: 8] : pat_high[8*(i-8) +: 8];
        if (pb[i] == CH_NUL) begin
          n = i;
          break;
        end
      end
      elem_count = 0;
      anchored_end = 1'b0;
      anchored_start = (n > 0) && (pb[0] == CH_BEGIN);
      p = anchored_start ? 1 : 0;
      while (p < n) begin
        if (p + 1 < n && pb[p+1] == CH_STAR) begin
          elem_lit[elem_count] = pb[p];
          elem_any[elem_count] = (pb[p] == CH_ANY);
          elem_star[elem_count] = 1'b1;
          elem_count++;
          p += 2;
        end else if (pb[p] == CH_END && p + 1 == n) begin
          anchored_end = 1'b1;
          p += 1;
        end else begin
          elem_lit[elem_count] = pb[p];
          elem_any[elem_count] = (pb[p] == CH_ANY);
          elem_star[elem_count] = 1'b0;
          elem_count++;
          p += 1;
        end
      end
    endfunction

    function void write_reg(logic [REG_SEL_W-1:0] sel, logic [63:0] value);
      case (sel)
        REG_PAT_LOW: pat_low = value;
        REG_PAT_HIGH: pat_high = value;
        REG_PAT_LEN: pat_len = value[LEN_W-1:0];
        default: ;
      endcase
      compile_program();
    endfunction

    function int unsigned skip_stars(int unsigned s);
      for (int k = 0; k < elem_count; k++) begin
        if (s[k] && elem_star[k]) s[k+1] = 1'b1;
      end
      return s;
    endfunction

    function int unsigned step_byte(int unsigned s, logic [7:0] c);
      int unsigned nxt;
      nxt = 0;
      for (int k = 0; k < elem_count; k++) begin
        if (s[k] && (elem_any[k] || elem_lit[k] == c)) begin
          nxt[elem_star[k] ? k : k + 1] = 1'b1;
        end
      end
      return nxt;
    endfunction

    function void predict_request(logic [7:0] b, logic e);
      int unsigned mask;
      int unsigned accept_bit;
      int unsigned cur;
      result_t want;
      mask = (32'd1 << (elem_count + 1)) - 1;
      accept_bit = 32'd1 << elem_count;
      cur = (32'(live_pos) & mask) | ((!anchored_start || text_start) ? 32'd1 : 32'd0);
      cur = skip_stars(cur);
      requests++;
      if (e) begin
        if ((cur & accept_bit) != 0) found = 1'b1;
        want.match_found = found;
        want.verdict_final = 1'b1;
        texts_closed++;
        if (found) texts_matched++;
        live_pos = '0;
        found = 1'b0;
        text_start = 1'b1;
      end else begin
        if (!anchored_end && (cur & accept_bit) != 0) found = 1'b1;
        cur = skip_stars(step_byte(cur, b));
        if (!anchored_end && (cur & accept_bit) != 0) found = 1'b1;
        live_pos = cur[16:0];
        text_start = 1'b0;
        want.match_found = found;
        want.verdict_final = 1'b0;
      end
      flags_due.push_back(want);
    endfunction

    function void check_result(logic mf, logic vf);
      result_t want;
      if (flags_due.size() == 0) begin
        errors++;
        $display("%0t: result with no request waiting: found=%b final=%b", $time, mf, vf);
        return;
      end
      want = flags_due.pop_front();
      if (mf !== want.match_found) begin
        errors++;
        $display("%0t: match_found mismatch: expected %b, actual %b",
                 $time, want.match_found, mf);
      end
      if (vf !== want.verdict_final) begin
        errors++;
        $display("%0t: verdict_final mismatch: expected %b, actual %b",
                 $time, want.verdict_final, vf);
      end
    endfunction

    function int pending();
      return flags_due.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  rsm_text_if   text_ch ();
  rsm_result_if result_ch ();

  match_tracker tracker;
  bit           src_quiet;
  bit           sink_quiet;
  int           idle_cycles;
  int           settings_used;

  regex_stream_matcher i_dut (
    .clk     (clk),
    .rst     (rst),
    .text    (text_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_request(input logic [7:0] b, input logic e);
    int unsigned gap;
    gap = src_quiet ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid      <= 1'b1;
    text_ch.text_byte  <= b;
    text_ch.end_marker <= e;
    do @(posedge clk); while (!text_ch.ready);
    tracker.predict_request(b, e);
  endtask

  task automatic run_text(input string s, input bit close_text);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
    if (close_text) send_request(8'($urandom), 1'b1);
  endtask

  task automatic drain_stream();
    text_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic write_reg(input logic [REG_SEL_W-1:0] sel, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({sel, 3'b000});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.write_reg(sel, value);
    @(posedge clk);
  endtask

  task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] len);
    drain_stream();
    write_reg(REG_PAT_LOW, lo);
    write_reg(REG_PAT_HIGH, hi);
    write_reg(REG_PAT_LEN, 64'(len));
    settings_used++;
  endtask

  function automatic void pack_string(input string s, output logic [63:0] lo,
                                      output logic [63:0] hi);
    lo = '0;
    hi = '0;
    for (int i = 0; i < s.len() && i < PAT_BYTES; i++) begin
      if (i < 8) lo[8*i +: 8] = s[i];
      else hi[8*(i-8) +: 8] = s[i];
    end
  endfunction

  function automatic void random_pattern(output logic [63:0] lo, output logic [63:0] hi,
                                         output logic [4:0] len);
    logic [7:0] pb [PAT_BYTES];
    int n;
    int r;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 8);
    for (int i = 0; i < PAT_BYTES; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) pb[i] = CH_A + 8'($urandom_range(0, 2));
      else if (r < 65) pb[i] = CH_ANY;
      else if (r < 80) pb[i] = CH_STAR;
      else if (r < 85) pb[i] = CH_END;
      else if (r < 89) pb[i] = CH_BEGIN;
      else if (r < 92) pb[i] = CH_NUL;
      else pb[i] = 8'($urandom_range(1, 255));
    end
    if (n > 0 && $urandom_range(0, 2) == 0) pb[0] = CH_BEGIN;
    if (n > 0 && $urandom_range(0, 2) == 0) pb[n-1] = CH_END;
    for (int i = 0; i < PAT_BYTES; i++) begin
      if (i < 8) lo[8*i +: 8] = pb[i];
      else hi[8*(i-8) +: 8] = pb[i];
    end
    len = (n == 16 && $urandom_range(0, 1) == 1) ? 5'($urandom_range(17, 31)) : 5'(n);
  endfunction

  function automatic logic [7:0] random_text_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return CH_A + 8'($urandom_range(0, 2));
    if (r == 6) begin
      case ($urandom_range(0, 3))
        0: return CH_STAR;
        1: return CH_ANY;
        2: return CH_END;
        default: return CH_BEGIN;
      endcase
    end
    return 8'($urandom_range(1, 255));
  endfunction

  initial begin : result_sink
    int unsigned hold;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = sink_quiet ? 0 : $urandom_range(0, 14);
      if (hold != 0) begin
        result_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      tracker.check_result(result_ch.match_found, result_ch.verdict_final);
    end
  end

  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    int          mode;
    int          n_texts;
    int          text_len;
    tracker = new();
    src_quiet = 1'b0;
    sink_quiet = 1'b0;
    settings_used = 1;
    idle_cycles = 0;
    rst <= 1'b1;
    text_ch.valid <= 1'b0;
    text_ch.text_byte <= '0;
    text_ch.end_marker <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    run_text("", 1'b1);
    pack_string("^a?c*$", lo, hi);
    load_pattern(lo, hi, 5'd6);
    send_request(CH_A, 1'b0);
    send_request(CH_NUL, 1'b0);
    send_request(CH_A + 8'd2, 1'b0);
    send_request(8'hFF, 1'b1);
    pack_string("*ab**$*", lo, hi);
    load_pattern(lo, hi, 5'd7);
    run_text("*abb*$$", 1'b1);
    pack_string("a^b$c", lo, hi);
    load_pattern(lo, hi, 5'd5);
    run_text("a^b$c", 1'b1);
    load_pattern('1, '1, 5'd31);
    send_request(8'hFF, 1'b0);
    send_request(8'h01, 1'b0);
    // The next pattern is loaded in the middle of an open text.
    pack_string("ab?c", lo, hi);
    lo[23:16] = CH_NUL;
    load_pattern(lo, hi, 5'd4);
    run_text("ab", 1'b1);

    while (tracker.requests < 600) begin
      src_quiet = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
        random_pattern(lo, hi, len);
        load_pattern(lo, hi, len);
      end else begin
        drain_stream();
        if (mode < 9) write_reg(REG_PAT_LEN, 64'($urandom_range(0, 31)));
        else write_reg(REG_PAT_HIGH, {$urandom, $urandom});
        settings_used++;
      end
      n_texts = $urandom_range(1, 6);
      for (int t = 0; t < n_texts; t++) begin
        text_len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 24) : $urandom_range(0, 10);
        repeat (text_len) send_request(random_text_byte(), 1'b0);
        if (t + 1 < n_texts || $urandom_range(0, 4) != 0) send_request(8'($urandom), 1'b1);
      end
    end

    drain_stream();
    repeat (10) @(posedge clk);
    $display("Streamed %0d requests in %0d closed texts, %0d of them matching.",
             tracker.requests, tracker.texts_closed, tracker.texts_matched);
    $display("Used %0d pattern settings, with and without idle gaps on both channels.",
             settings_used);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== regex_stream_matcher.f =====
sv/rsm_pkg.sv
sv/rsm_stream_ifs.sv
sv/rsm_config.sv
sv/rsm_cell.sv
sv/regex_stream_matcher.sv
sv/rsm_chk.sv
verif/regex_stream_matcher_tb.sv
